/* hw/rtl/cwm_pkg.sv */
package cwm_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_KERNEL  = 5;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_FRAC   = 12;
    localparam int ROW_LIMIT   = 1024;
    localparam int TAPS        = MAX_KERNEL * MAX_KERNEL;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(ROW_LIMIT);
    localparam int SLOT_W  = $clog2(MAX_KERNEL);
    localparam int CSLOT_W = 5;
    localparam int DIM_W   = 11;
    localparam int WIN_W   = 3;
    localparam int CFG_W   = 11;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W  = 2 * SAMPLE_BITS;
    localparam int ROWSUM_W = PROD_W + $clog2(MAX_KERNEL) + 1;
    localparam int SUM_W   = PROD_W + $clog2(TAPS) + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMG_W = 2'd0,
        CFG_IMG_H = 2'd1,
        CFG_WIN_W = 2'd2,
        CFG_WIN_H = 2'd3
    } t_cfg_idx;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    typedef struct packed {
        logic shift;
        logic calc;
        logic live;
    } t_cell_ctl;

    // Bank holding the row k lines above the one in bank slot.
    function automatic logic [SLOT_W-1:0] f_slot_back(logic [SLOT_W-1:0] slot, int k);
        logic [SLOT_W:0] tmp;
        tmp = (SLOT_W+1)'(slot) + (SLOT_W+1)'(MAX_KERNEL - k);
        if (tmp >= (SLOT_W+1)'(MAX_KERNEL)) begin
            tmp = tmp - (SLOT_W+1)'(MAX_KERNEL);
        end
        return tmp[SLOT_W-1:0];
    endfunction

    // Coefficient slot for window cell (i,j) under a kw x kh kernel.
    function automatic logic [CSLOT_W-1:0] f_coef_idx(logic [WIN_W-1:0] kw,
                                                     logic [WIN_W-1:0] kh,
                                                     int i, int j);
        int kx;
        int ky;
        kx = int'(kw) + j - MAX_KERNEL;
        ky = int'(kh) + i - MAX_KERNEL;
        if (kx < 0 || ky < 0) begin
            return '0;
        end
        return CSLOT_W'(ky * MAX_KERNEL + kx);
    endfunction

endpackage

/* hw/rtl/cwm_ram.sv */
module cwm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/cwm_cell.sv */
module cwm_cell (
    input  logic                                   i_clk,
    input  cwm_pkg::t_cell_ctl                     i_ctl,
    input  logic signed [cwm_pkg::SAMPLE_BITS-1:0] i_pix,
    input  logic signed [cwm_pkg::SAMPLE_BITS-1:0] i_coef,
    output logic signed [cwm_pkg::SAMPLE_BITS-1:0] o_pix,
    output logic signed [cwm_pkg::PROD_W-1:0]      o_prod
);
    import cwm_pkg::*;

    logic signed [SAMPLE_BITS-1:0] r_pix;
    logic signed [PROD_W-1:0]      r_prod;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_pix <= i_pix;
        end
        if (i_ctl.calc) begin
            // drop taps outside the image or the kernel
            if (i_ctl.live) begin
                r_prod <= r_pix * i_coef;
            end else begin
                r_prod <= '0;
            end
        end
    end

    assign o_pix  = r_pix;
    assign o_prod = r_prod;

endmodule

/* hw/rtl/conv2d_window_mac.sv */
// Pipeline: line bank read, window shift, multiply, row sums, total, output word.
// Throughput: one word per cycle while o_stall is low, pixel or coefficient load;
//   cells shift on pixels, multiply when unstalled; banks take one write, one read.
// Reset (synchronous, active low): registers to 64x64 image, 3x3 kernel,
//   coefficients zero, raster position zero, pipeline empty.
// Line banks need no clearing: only rows of the current frame are ever used.
module conv2d_window_mac (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [cwm_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [cwm_pkg::CFG_W-1:0]              i_cfg_data,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic                                   i_command,
    input  logic [cwm_pkg::CSLOT_W-1:0]            i_coef_slot,
    input  logic signed [cwm_pkg::SAMPLE_BITS-1:0] i_sample,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [cwm_pkg::SAMPLE_BITS-1:0] o_pixel_out,
    output logic [cwm_pkg::COL_W-1:0]              o_out_col,
    output logic [cwm_pkg::ROW_W-1:0]              o_out_row,
    output logic                                   o_frame_last
);
    import cwm_pkg::*;

    localparam int K = MAX_KERNEL;

    typedef struct packed {
        logic             last;
        logic [COL_W-1:0] x;
        logic [ROW_W-1:0] y;
    } t_tag;

    // configuration
    logic [DIM_W-1:0] r_img_w, r_img_h;
    logic [WIN_W-1:0] r_win_w, r_win_h;
    logic [DIM_W-1:0] w, h;
    logic [WIN_W-1:0] kw, kh;

    always_comb begin
        w  = (r_img_w == '0) ? DIM_W'(1) :
             (r_img_w > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : r_img_w;
        h  = (r_img_h == '0) ? DIM_W'(1) :
             (r_img_h > DIM_W'(ROW_LIMIT)) ? DIM_W'(ROW_LIMIT) : r_img_h;
        kw = (r_win_w == '0) ? WIN_W'(1) :
             (r_win_w > WIN_W'(K)) ? WIN_W'(K) : r_win_w;
        kh = (r_win_h == '0) ? WIN_W'(1) :
             (r_win_h > WIN_W'(K)) ? WIN_W'(K) : r_win_h;
    end

    // handshake
    logic en, acc, acc_pix;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;
    assign acc     = i_valid && en;
    assign acc_pix = acc && (i_command == CMD_PIXEL);

    // raster position
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [SLOT_W-1:0] r_slot;

    // emit decision at accept
    logic [WIN_W-1:0] rx, ry;
    logic [DIM_W:0]   xe, ye;
    logic             emit0, last0;
    logic [COL_W-1:0] x0;
    logic [ROW_W-1:0] y0;

    always_comb begin
        rx = kw - WIN_W'(1) - (kw >> 1);
        ry = kh - WIN_W'(1) - (kh >> 1);
        xe = (DIM_W+1)'(r_col) - (DIM_W+1)'(rx);
        ye = (DIM_W+1)'(r_row) - (DIM_W+1)'(ry);
        x0 = xe[COL_W-1:0];
        y0 = ye[ROW_W-1:0];
        emit0 = (r_col >= COL_W'(rx)) && (r_row >= ROW_W'(ry))
             && (xe + (DIM_W+1)'(kw) <= (DIM_W+1)'(w))
             && (ye + (DIM_W+1)'(kh) <= (DIM_W+1)'(h));
        last0 = (xe + (DIM_W+1)'(kw) == (DIM_W+1)'(w))
             && (ye + (DIM_W+1)'(kh) == (DIM_W+1)'(h));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= DIM_W'(64);
            r_img_h <= DIM_W'(64);
            r_win_w <= WIN_W'(3);
            r_win_h <= WIN_W'(3);
            r_col   <= '0;
            r_row   <= '0;
            r_slot  <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_IMG_W: r_img_w <= i_cfg_data[DIM_W-1:0];
                CFG_IMG_H: r_img_h <= i_cfg_data[DIM_W-1:0];
                CFG_WIN_W: r_win_w <= i_cfg_data[WIN_W-1:0];
                CFG_WIN_H: r_win_h <= i_cfg_data[WIN_W-1:0];
                default:   r_img_w <= r_img_w;
            endcase
            // restart the frame
            r_col  <= '0;
            r_row  <= '0;
            r_slot <= '0;
        end else if (acc_pix) begin
            if ((DIM_W)'(r_col) + DIM_W'(1) >= w) begin
                r_col <= '0;
                if ((DIM_W)'(r_row) + DIM_W'(1) >= h) begin
                    r_row  <= '0;
                    r_slot <= '0;
                end else begin
                    r_row  <= r_row + ROW_W'(1);
                    r_slot <= (r_slot == SLOT_W'(K - 1)) ? '0 : r_slot + SLOT_W'(1);
                end
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // line banks, row r kept in bank r mod K
    logic [SAMPLE_BITS-1:0] bank_q [K];

    for (genvar b = 0; b < K; b++) begin : g_bank
        cwm_ram #(
            .WIDTH (SAMPLE_BITS),
            .DEPTH (MAX_WIDTH)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (acc_pix && (r_slot == SLOT_W'(b))),
            .i_waddr (r_col),
            .i_wdata (i_sample),
            .i_re    (acc_pix),
            .i_raddr (r_col),
            .o_rdata (bank_q[b])
        );
    end

    // stage 1: bank data arrives
    logic                          r_p1_pix, r_p1_load, r_p1_emit;
    logic [CSLOT_W-1:0]            r_p1_cslot;
    logic signed [SAMPLE_BITS-1:0] r_p1_sample;
    logic [COL_W-1:0]              r_p1_col;
    logic [ROW_W-1:0]              r_p1_row;
    logic [SLOT_W-1:0]             r_p1_slot;
    t_tag                          r_p1_tag;

    // stage 2: window holds the item
    logic                          r_p2_load, r_p2_emit;
    logic [CSLOT_W-1:0]            r_p2_cslot;
    logic signed [SAMPLE_BITS-1:0] r_p2_sample;
    logic [COL_W-1:0]              r_p2_col;
    logic [ROW_W-1:0]              r_p2_row;
    t_tag                          r_p2_tag;

    // stages 3..5
    logic r_p3_emit, r_p4_emit, r_p5_emit;
    t_tag r_p3_tag, r_p4_tag, r_p5_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_pix  <= 1'b0;
            r_p1_load <= 1'b0;
            r_p1_emit <= 1'b0;
            r_p2_load <= 1'b0;
            r_p2_emit <= 1'b0;
            r_p3_emit <= 1'b0;
            r_p4_emit <= 1'b0;
            r_p5_emit <= 1'b0;
        end else if (en) begin
            r_p1_pix  <= acc_pix;
            r_p1_load <= acc && (i_command == CMD_LOAD);
            r_p1_emit <= acc_pix && emit0;
            r_p2_load <= r_p1_load;
            r_p2_emit <= r_p1_emit;
            r_p3_emit <= r_p2_emit;
            r_p4_emit <= r_p3_emit;
            r_p5_emit <= r_p4_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1_cslot  <= i_coef_slot;
            r_p1_sample <= i_sample;
            r_p1_col    <= r_col;
            r_p1_row    <= r_row;
            r_p1_slot   <= r_slot;
            r_p1_tag    <= '{last: last0, x: x0, y: y0};
            r_p2_cslot  <= r_p1_cslot;
            r_p2_sample <= r_p1_sample;
            r_p2_col    <= r_p1_col;
            r_p2_row    <= r_p1_row;
            r_p2_tag    <= r_p1_tag;
            r_p3_tag    <= r_p2_tag;
            r_p4_tag    <= r_p3_tag;
            r_p5_tag    <= r_p4_tag;
        end
    end

    // coefficients, written in stream order at the multiply stage
    logic signed [SAMPLE_BITS-1:0] r_coef [TAPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < TAPS; t++) begin
                r_coef[t] <= '0;
            end
        end else if (en && r_p2_load && (r_p2_cslot < CSLOT_W'(TAPS))) begin
            r_coef[r_p2_cslot] <= r_p2_sample;
        end
    end

    // new window column: current pixel on the bottom row
    logic signed [SAMPLE_BITS-1:0] column [K];

    always_comb begin
        for (int i = 0; i < K; i++) begin
            column[i] = $signed(bank_q[f_slot_back(r_p1_slot, K - 1 - i)]);
        end
        column[K-1] = r_p1_sample;
    end

    // window cells: row i back K-1-i lines, column j back K-1-j pixels
    logic signed [SAMPLE_BITS-1:0] cell_pix  [K][K];
    logic signed [PROD_W-1:0]      cell_prod [K][K];

    for (genvar i = 0; i < K; i++) begin : g_row
        for (genvar j = 0; j < K; j++) begin : g_col
            t_cell_ctl                     ctl;
            logic signed [SAMPLE_BITS-1:0] pix_in;
            logic [CSLOT_W-1:0]            cidx;

            assign cidx = f_coef_idx(kw, kh, i, j);
            assign pix_in = (j == K - 1) ? column[i] : cell_pix[i][(j + 1) % K];
            assign ctl.shift = en && r_p1_pix;
            assign ctl.calc  = en;
            assign ctl.live  = (int'(kw) + j >= K) && (int'(kh) + i >= K)
                            && (r_p2_col >= COL_W'(K - 1 - j))
                            && (r_p2_row >= ROW_W'(K - 1 - i));

            cwm_cell u_cell (
                .i_clk  (i_clk),
                .i_ctl  (ctl),
                .i_pix  (pix_in),
                .i_coef (r_coef[cidx]),
                .o_pix  (cell_pix[i][j]),
                .o_prod (cell_prod[i][j])
            );
        end
    end

    // stage 4: row sums; stage 5: total
    logic signed [ROWSUM_W-1:0] row_sum [K];
    logic signed [ROWSUM_W-1:0] r_row_sum [K];
    logic signed [SUM_W-1:0]    total;
    logic signed [SUM_W-1:0]    r_total;

    always_comb begin
        for (int i = 0; i < K; i++) begin
            row_sum[i] = '0;
            for (int j = 0; j < K; j++) begin
                row_sum[i] = row_sum[i] + ROWSUM_W'(cell_prod[i][j]);
            end
        end
        total = '0;
        for (int i = 0; i < K; i++) begin
            total = total + SUM_W'(r_row_sum[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_row_sum <= row_sum;
            r_total   <= total;
        end
    end

    // round half up, floor shift, saturate
    localparam logic signed [SUM_W:0] SAT_HI = (SUM_W+1)'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SUM_W:0] SAT_LO = -SAT_HI - (SUM_W+1)'(1);

    logic signed [SUM_W:0]         rnd, q;
    logic signed [SAMPLE_BITS-1:0] sat;

    always_comb begin
        rnd = (SUM_W+1)'(r_total) + (SUM_W+1)'(COEF_FRAC > 0 ? (1 << (COEF_FRAC - 1)) : 0);
        q   = (COEF_FRAC > 0) ? (rnd >>> COEF_FRAC) : (SUM_W+1)'(r_total);
        if (q > SAT_HI) begin
            sat = SAT_HI[SAMPLE_BITS-1:0];
        end else if (q < SAT_LO) begin
            sat = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            sat = q[SAMPLE_BITS-1:0];
        end
    end

    // output word
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_pixel_out;
    logic [COL_W-1:0]              r_out_col;
    logic [ROW_W-1:0]              r_out_row;
    logic                          r_frame_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_p5_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_p5_emit) begin
            r_pixel_out  <= sat;
            r_out_col    <= r_p5_tag.x;
            r_out_row    <= r_p5_tag.y;
            r_frame_last <= r_p5_tag.last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_pixel_out  = r_pixel_out;
    assign o_out_col    = r_out_col;
    assign o_out_row    = r_out_row;
    assign o_frame_last = r_frame_last;

`ifndef ASSERT_OFF
    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        DIM_W'(r_col) < w)
        else $error("column counter beyond image width");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot < SLOT_W'(K))
        else $error("line bank slot out of range");

    a_load_no_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_command == CMD_LOAD)) |=> !r_p1_emit)
        else $error("coefficient load produced a result");

    a_out_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((DIM_W+1)'(o_out_col) + (DIM_W+1)'(kw) <= (DIM_W+1)'(w)))
        else $error("output column beyond valid range");

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_last) |->
            ((DIM_W+1)'(o_out_row) + (DIM_W+1)'(kh) == (DIM_W+1)'(h)))
        else $error("frame end flagged on wrong row");
`endif

endmodule
